// File: rtl/sdx_pkg.sv
// Shared types and constants for the disparity-to-XYZ triangulation core.
package sdx_pkg;

   localparam int CoefW  = 21;  // packed Q2.18 entry
   localparam int PackW  = 63;  // three packed entries
   localparam int DiffW  = 18;  // disparity minus center offset
   localparam int TW     = 36;  // ray component, Q.18
   localparam int TMagW  = 35;
   localparam int ProdW  = 57;  // ray times axis, Q.36
   localparam int DotW   = 41;  // rounded dot, Q.18
   localparam int DenW   = 60;  // signed denominator
   localparam int DW     = 59;  // denominator magnitude
   localparam int NW     = 69;  // baseline_focal * 4 * |t|
   localparam int QW     = 41;  // quotient bits, last one is the cap bit
   localparam int RW     = 60;  // partial remainder
   localparam int HiW    = NW - QW;
   localparam int OutW   = 32;
   localparam int SumW   = 42;

   typedef enum logic [2:0] {
      CSR_RAY_X    = 3'd0,
      CSR_RAY_Y    = 3'd1,
      CSR_RAY_Z    = 3'd2,
      CSR_AXIS     = 3'd3,
      CSR_CAM_POS  = 3'd4,
      CSR_BASE_FOC = 3'd5,
      CSR_CENTER   = 3'd6,
      CSR_INVALID  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0][PackW-1:0] ray;
      logic [PackW-1:0]      axis;
      logic [31:0]           base_foc;
      logic [16:0]           center;
      logic [15:0]           invalid;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       ok;
      logic       nz;
      logic [2:0] neg;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic [DW-1:0]         den;
      logic [2:0][RW-1:0]    rem;
      logic [2:0][QW-1:0]    numlo;
      logic [2:0][QW-1:0]    quo;
      logic [2:0]            cap;
   } div_stage_type;

endpackage

// File: rtl/sdx_front.sv
// Front pipeline: ray, axis dot, denominator and divider set-up.
module sdx_front #(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [11:0]           row,
   input  logic [11:0]           col,
   input  logic [15:0]           disp,
   input  sdx_pkg::cfg_type      cfg,
   output sdx_pkg::div_stage_type stage_out
);

   logic                     ok_in;
   logic [sdx_pkg::DiffW-1:0] diff_in;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic ok0_ff, ok1_ff, ok2_ff, ok3_ff, ok4_ff, ok5_ff;
   logic [11:0] row0_ff, col0_ff;
   logic [sdx_pkg::DiffW-1:0] diff0_ff, diff1_ff, diff2_ff, diff3_ff, diff4_ff, diff5_ff;

   logic signed [2:0][33:0] pc1_ff, pr1_ff;
   logic signed [2:0][sdx_pkg::TW-1:0] t2_ff;
   logic signed [2:0][sdx_pkg::TW-1:0] t2_in;
   logic signed [2:0][sdx_pkg::ProdW-1:0] pa3_ff;
   logic [2:0][sdx_pkg::NW-1:0] num3_ff, num4_ff, num5_ff;
   logic [2:0] neg3_ff, neg4_ff, neg5_ff;
   logic signed [sdx_pkg::DotW-1:0] dot4_ff;
   logic signed [sdx_pkg::DenW-1:0] den5_ff;

   logic signed [58:0]           dot_sum;
   logic                         nz;
   logic [sdx_pkg::DenW-1:0]     den_abs;
   logic [sdx_pkg::DW-1:0]       dmag;
   sdx_pkg::div_stage_type       stage_in, stage_ff;

   assign ok_in = ({5'b0, row} < 17'(MAX_ROWS)) && ({5'b0, col} < 17'(MAX_COLS)) &&
                  (disp != cfg.invalid) &&
                  ($signed({2'b00, disp}) > $signed({cfg.center[16], cfg.center}));
   assign diff_in = {2'b00, disp} - {cfg.center[16], cfg.center};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t2_in[i] = sdx_pkg::TW'($signed(pc1_ff[i])) + sdx_pkg::TW'($signed(pr1_ff[i])) +
                    sdx_pkg::TW'($signed(cfg.ray[i][62:42]));
      end
   end

   assign dot_sum = 59'($signed(pa3_ff[0])) + 59'($signed(pa3_ff[1])) +
                    59'($signed(pa3_ff[2])) + 59'sd131072;

   // near-zero denominator: replace the dot by one
   assign nz      = (den5_ff > -60'sd3) && (den5_ff < 60'sd3);
   assign den_abs = den5_ff[sdx_pkg::DenW-1] ? sdx_pkg::DenW'(-den5_ff) : den5_ff;
   assign dmag    = nz ? sdx_pkg::DW'({diff5_ff, 18'b0}) : den_abs[sdx_pkg::DW-1:0];

   always_comb begin
      stage_in.side.valid = v5_ff;
      stage_in.side.ok    = ok5_ff;
      stage_in.side.nz    = nz;
      stage_in.den        = dmag;
      for (int i = 0; i < 3; i++) begin
         stage_in.side.neg[i] = neg5_ff[i] ^ (!nz && den5_ff[sdx_pkg::DenW-1]);
         stage_in.rem[i]   = sdx_pkg::RW'(num5_ff[i][sdx_pkg::NW-1:sdx_pkg::QW]);
         stage_in.numlo[i] = num5_ff[i][sdx_pkg::QW-1:0];
         stage_in.quo[i]   = '0;
         stage_in.cap[i]   = sdx_pkg::DW'(num5_ff[i][sdx_pkg::NW-1:sdx_pkg::QW]) >= dmag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0;
         v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         stage_ff.side.valid <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid; v1_ff <= v0_ff; v2_ff <= v1_ff;
         v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row0_ff  <= row;
         col0_ff  <= col;
         ok0_ff   <= ok_in;
         diff0_ff <= diff_in;
         for (int i = 0; i < 3; i++) begin
            pc1_ff[i] <= 34'($signed(cfg.ray[i][20:0]) * $signed({1'b0, col0_ff}));
            pr1_ff[i] <= 34'($signed(cfg.ray[i][41:21]) * $signed({1'b0, row0_ff}));
            t2_ff[i]  <= t2_in[i];
            pa3_ff[i] <= sdx_pkg::ProdW'($signed(t2_ff[i]) *
                                         $signed(cfg.axis[21*i +: 21]));
            neg3_ff[i] <= t2_ff[i][sdx_pkg::TW-1];
            num3_ff[i] <= sdx_pkg::NW'({cfg.base_foc, 2'b00}) *
                          sdx_pkg::NW'(t2_ff[i][sdx_pkg::TW-1] ?
                             sdx_pkg::TMagW'(-t2_ff[i]) : sdx_pkg::TMagW'(t2_ff[i]));
         end
         ok1_ff <= ok0_ff; diff1_ff <= diff0_ff;
         ok2_ff <= ok1_ff; diff2_ff <= diff1_ff;
         ok3_ff <= ok2_ff; diff3_ff <= diff2_ff;
         ok4_ff <= ok3_ff; diff4_ff <= diff3_ff;
         ok5_ff <= ok4_ff; diff5_ff <= diff4_ff;
         dot4_ff <= dot_sum[58:18];
         num4_ff <= num3_ff; neg4_ff <= neg3_ff;
         num5_ff <= num4_ff; neg5_ff <= neg4_ff;
         den5_ff <= sdx_pkg::DenW'($signed({1'b0, diff4_ff}) * dot4_ff);
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: rtl/sdx_div_cell.sv
// One restoring-divide cell: one quotient bit for each of the three lanes.
module sdx_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  sdx_pkg::div_stage_type stage_in,
   output sdx_pkg::div_stage_type stage_out
);

   sdx_pkg::div_stage_type cell_in, cell_ff;
   logic [2:0][sdx_pkg::RW:0] r2;
   logic [2:0]                ge;

   always_comb begin
      cell_in = stage_in;
      for (int i = 0; i < 3; i++) begin
         r2[i] = {stage_in.rem[i], stage_in.numlo[i][sdx_pkg::QW-1]};
         ge[i] = r2[i] >= (sdx_pkg::RW+1)'(stage_in.den);
         cell_in.rem[i] = ge[i] ? sdx_pkg::RW'(r2[i] - (sdx_pkg::RW+1)'(stage_in.den))
                                : sdx_pkg::RW'(r2[i]);
         cell_in.numlo[i] = {stage_in.numlo[i][sdx_pkg::QW-2:0], 1'b0};
         cell_in.quo[i]   = {stage_in.quo[i][sdx_pkg::QW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign stage_out = cell_ff;

endmodule

// File: rtl/stereo_disparity_to_xyz_core.sv
// Pipeline: 7 front stages, 41 divide cells and the output register, from request to result.
// Throughput: one request per cycle while the pipeline advances; the divide cell row passes data every cycle.
// The whole pipeline holds while a result waits under rsp_stall.
// Reset: synchronous, active high; clears valid bits, CSR registers take their reset values, datapath is not reset.
// Top level: stereo disparity to XYZ triangulation core.
module stereo_disparity_to_xyz_core #(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_row,
   input  logic [11:0] req_pixel_col,
   input  logic [15:0] req_disparity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic        rsp_range_valid,
   output logic        rsp_near_zero_scale,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [62:0] csr_data
);

   localparam int NCells = sdx_pkg::QW;

   sdx_pkg::cfg_type cfg_ff;
   logic [62:0]      cam_pos_ff;
   logic             adv;

   sdx_pkg::div_stage_type chain [NCells+1];

   logic                               rsp_valid_ff;
   logic signed [2:0][31:0]            pos_ff;
   logic                               range_ff, nz_ff;
   logic signed [2:0][31:0]            pos_in;
   sdx_pkg::div_stage_type             last;

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ray      <= '0;
         cfg_ff.axis     <= '0;
         cfg_ff.base_foc <= '0;
         cfg_ff.center   <= '0;
         cfg_ff.invalid  <= 16'hFFFF;
         cam_pos_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (sdx_pkg::csr_index_type'(csr_index))
            sdx_pkg::CSR_RAY_X:    cfg_ff.ray[0]   <= csr_data;
            sdx_pkg::CSR_RAY_Y:    cfg_ff.ray[1]   <= csr_data;
            sdx_pkg::CSR_RAY_Z:    cfg_ff.ray[2]   <= csr_data;
            sdx_pkg::CSR_AXIS:     cfg_ff.axis     <= csr_data;
            sdx_pkg::CSR_CAM_POS:  cam_pos_ff      <= csr_data;
            sdx_pkg::CSR_BASE_FOC: cfg_ff.base_foc <= csr_data[31:0];
            sdx_pkg::CSR_CENTER:   cfg_ff.center   <= csr_data[16:0];
            sdx_pkg::CSR_INVALID:  cfg_ff.invalid  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   sdx_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .row       (req_pixel_row),
      .col       (req_pixel_col),
      .disp      (req_disparity),
      .cfg       (cfg_ff),
      .stage_out (chain[0])
   );

   for (genvar g = 0; g < NCells; g++) begin : g_cell
      sdx_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   assign last = chain[NCells];

   always_comb begin
      logic [sdx_pkg::QW-1:0]          qmag;
      logic signed [sdx_pkg::SumW-1:0] sval;
      for (int i = 0; i < 3; i++) begin
         // cap the quotient at 2^40
         qmag = (last.cap[i] || last.quo[i][sdx_pkg::QW-1]) ?
                {1'b1, {(sdx_pkg::QW-1){1'b0}}} : last.quo[i];
         sval = (last.side.neg[i] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag})) +
                sdx_pkg::SumW'($signed(cam_pos_ff[21*i +: 21]));
         if (!last.side.ok)
            pos_in[i] = '0;
         else if (sval > 42'sd2147483647)
            pos_in[i] = 32'sh7FFFFFFF;
         else if (sval < -42'sd2147483648)
            pos_in[i] = 32'sh80000000;
         else
            pos_in[i] = sval[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff   <= pos_in;
         range_ff <= last.side.ok;
         nz_ff    <= last.side.ok && last.side.nz;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pos_x           = pos_ff[0];
   assign rsp_pos_y           = pos_ff[1];
   assign rsp_pos_z           = pos_ff[2];
   assign rsp_range_valid     = range_ff;
   assign rsp_near_zero_scale = nz_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_valid |->
         rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0 && !rsp_near_zero_scale)
      else $error("invalid pixel result not cleared");
   a_nz_needs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_near_zero_scale |-> rsp_range_valid)
      else $error("near-zero flag without range");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// File: dv/stereo_disparity_to_xyz_core_tb.sv
// Self-checking testbench for the disparity-to-XYZ triangulation core.
`timescale 1ns / 100ps

module stereo_disparity_to_xyz_core_tb;

   localparam int ROWS = 4096;
   localparam int COLS = 4096;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic               rv, nz;
   } xyz_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_pixel_row = '0;
   logic [11:0] req_pixel_col = '0;
   logic [15:0] req_disparity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic        rsp_range_valid, rsp_near_zero_scale;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [62:0] csr_data = '0;

   logic [62:0] cfg_reg [8];
   xyz_type     pending_xyz [$];
   int          errors = 0;
   bit          hold_long = 0;
   bit          stall_quiet = 0;

   stereo_disparity_to_xyz_core #(.MAX_ROWS(ROWS), .MAX_COLS(COLS)) DUT (.*);

   always #4 clock = ~clock;

   function automatic longint f21(logic [62:0] r, int k);
      logic signed [20:0] v;
      v = r[21*k +: 21];
      return longint'(v);
   endfunction

   // Bit-exact prediction of one pixel.
   function automatic xyz_type triangulate(logic [11:0] row, logic [11:0] col,
                                           logic [15:0] disp);
      xyz_type r;
      longint center, t [3], dot36, dot, diff, den, v;
      logic [127:0] num, dm, tm, q;
      r = '{0, 0, 0, 0, 0};
      center = longint'($signed(cfg_reg[sdx_pkg::CSR_CENTER][16:0]));
      if (row >= ROWS || col >= COLS || disp == cfg_reg[sdx_pkg::CSR_INVALID][15:0] ||
          longint'(disp) <= center) return r;
      dot36 = 0;
      for (int i = 0; i < 3; i++) begin
         t[i] = f21(cfg_reg[i], 0) * longint'(col) + f21(cfg_reg[i], 1) * longint'(row)
                + f21(cfg_reg[i], 2);
         dot36 += t[i] * f21(cfg_reg[sdx_pkg::CSR_AXIS], i);
      end
      dot = (dot36 + 131072) >>> 18;
      diff = longint'(disp) - center;
      den = diff * dot;
      if (den > -3 && den < 3) begin
         den = diff * 262144;
         r.nz = 1'b1;
      end
      dm = (den < 0) ? 128'(-den) : 128'(den);
      for (int i = 0; i < 3; i++) begin
         tm = (t[i] < 0) ? 128'(-t[i]) : 128'(t[i]);
         num = 128'(cfg_reg[sdx_pkg::CSR_BASE_FOC][31:0]) * 4 * tm;
         q = num / dm;
         if (q > (128'd1 << 40)) q = 128'd1 << 40;
         v = ((t[i] < 0) != (den < 0)) ? -longint'(q) : longint'(q);
         v += f21(cfg_reg[sdx_pkg::CSR_CAM_POS], i);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         if (i == 0) r.px = v[31:0];
         else if (i == 1) r.py = v[31:0];
         else r.pz = v[31:0];
      end
      r.rv = 1'b1;
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Hold valid across back-to-back requests; drop it only for a gap.
   task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] disp,
                             bit gaps = 1);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_row <= row;
      req_pixel_col <= col;
      req_disparity <= disp;
      pending_xyz.push_back(triangulate(row, col, disp));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(sdx_pkg::csr_index_type idx, logic [62:0] val);
      logic [62:0] m;
      case (idx)
         sdx_pkg::CSR_BASE_FOC: m = 63'hFFFF_FFFF;
         sdx_pkg::CSR_CENTER:   m = 63'h1_FFFF;
         sdx_pkg::CSR_INVALID:  m = 63'hFFFF;
         default:               m = '1;
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cfg_reg[idx] = val & m;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_xyz.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [62:0] pack3(int a, int b, int c);
      return {21'(c), 21'(b), 21'(a)};
   endfunction

   // Plausible camera: ray ~ ((col-c0)/f, (row-c0)/f, 1), axis ~ z.
   task automatic load_camera(int f_inv, int c0);
      write_csr(sdx_pkg::CSR_RAY_X, pack3(f_inv, 0, -f_inv * c0));
      write_csr(sdx_pkg::CSR_RAY_Y, pack3(0, f_inv, -f_inv * c0));
      write_csr(sdx_pkg::CSR_RAY_Z, pack3($urandom_range(0, 7) - 3,
                                          $urandom_range(0, 7) - 3,
                                          262144 - $urandom_range(0, 200)));
      write_csr(sdx_pkg::CSR_AXIS, pack3($urandom_range(0, 255) - 128,
                                         $urandom_range(0, 255) - 128, 262143));
      write_csr(sdx_pkg::CSR_CAM_POS, pack3($urandom_range(0, 4095) - 2048,
                                            $urandom_range(0, 4095) - 2048,
                                            $urandom_range(0, 1023)));
      write_csr(sdx_pkg::CSR_BASE_FOC, 63'($urandom_range(20000, 4000000)));
      write_csr(sdx_pkg::CSR_CENTER, 63'($urandom_range(0, 64)));
      write_csr(sdx_pkg::CSR_INVALID, 63'hFFFF);
   endtask

   task automatic test_directed();
      load_camera(200, 2048);
      send_pixel(12'd0, 12'd0, 16'd100);
      send_pixel(12'hFFF, 12'hFFF, 16'hFFFE);
      send_pixel(12'hFFF, 12'd0, 16'hFFFF);                 // sentinel
      send_pixel(12'd0, 12'hFFF, 16'd0);                    // not above offset
      send_pixel(12'd100, 12'd200, 16'(cfg_reg[sdx_pkg::CSR_CENTER]));  // equal to offset
      send_pixel(12'd100, 12'd200, 16'(cfg_reg[sdx_pkg::CSR_CENTER] + 1));
      send_pixel(12'hAAA, 12'h555, 16'hAAAA);
      send_pixel(12'h555, 12'hAAA, 16'h5555);
      drain();
      // near-zero denominator: zero axis
      write_csr(sdx_pkg::CSR_AXIS, '0);
      send_pixel(12'd10, 12'd20, 16'd300);
      send_pixel(12'd4000, 12'd4000, 16'd1);
      drain();
      // extremes: saturation, negative offset, sentinel moved
      write_csr(sdx_pkg::CSR_RAY_X, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
      write_csr(sdx_pkg::CSR_RAY_Y, {21'h100000, 21'h100000, 21'h100000});
      write_csr(sdx_pkg::CSR_RAY_Z, pack3(1, 1, 1));
      write_csr(sdx_pkg::CSR_AXIS, pack3(1, 1, 1));
      write_csr(sdx_pkg::CSR_CAM_POS, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
      write_csr(sdx_pkg::CSR_BASE_FOC, 63'hFFFF_FFFF);
      write_csr(sdx_pkg::CSR_CENTER, 63'h1_0000);
      write_csr(sdx_pkg::CSR_INVALID, '0);
      send_pixel(12'hFFF, 12'hFFF, 16'd0);
      send_pixel(12'd0, 12'd0, 16'd1);
      send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
      send_pixel(12'd7, 12'd9, 16'd40000);
      drain();
      write_csr(sdx_pkg::CSR_CENTER, 63'h0_FFFF);
      write_csr(sdx_pkg::CSR_BASE_FOC, '0);
      send_pixel(12'd1, 12'd1, 16'hFFFF);
      send_pixel(12'd1, 12'd1, 16'hFFFE);
      drain();
   endtask

   task automatic test_random_camera(int count);
      logic [15:0] d;
      load_camera($urandom_range(60, 600), $urandom_range(0, 4095));
      for (int i = 0; i < count; i++) begin
         d = ($urandom_range(0, 9) == 0) ? 16'(cfg_reg[sdx_pkg::CSR_INVALID])
             : ($urandom_range(0, 9) == 0) ? 16'($urandom)
             : 16'(cfg_reg[sdx_pkg::CSR_CENTER] + $urandom_range(1, 4000));
         send_pixel(12'($urandom), 12'($urandom), d);
      end
      drain();
   endtask

   task automatic test_random_regs(int count);
      for (int k = 0; k < 8; k++)
         write_csr(sdx_pkg::csr_index_type'(k), 63'({$urandom, $urandom}));
      for (int i = 0; i < count; i++)
         send_pixel(12'($urandom), 12'($urandom), 16'($urandom));
      drain();
   endtask

   task automatic test_backpressure();
      load_camera(250, 1024);
      fork
         begin
            hold_long = 1;
            repeat (200) @(posedge clock);
            hold_long = 0;
         end
         for (int i = 0; i < 120; i++)
            send_pixel(12'($urandom), 12'($urandom), 16'($urandom_range(100, 3000)), 0);
      join
      stall_quiet = 1;
      for (int i = 0; i < 150; i++)
         send_pixel(12'($urandom), 12'($urandom), 16'($urandom_range(100, 3000)), 0);
      drain();
      stall_quiet = 0;
   endtask

   // Receiver stall: random gaps, a long hold-off, and clean stretches.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long || (!stall_quiet && gap_len() > 0)) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      xyz_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_xyz.size() == 0) begin
            $display("%0t: unexpected response x=%0d", $time, rsp_pos_x);
            errors++;
         end else begin
            e = pending_xyz.pop_front();
            if (e.px !== rsp_pos_x || e.py !== rsp_pos_y || e.pz !== rsp_pos_z ||
                e.rv !== rsp_range_valid || e.nz !== rsp_near_zero_scale) begin
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d v=%0b nz=%0b", $time,
                        e.px, e.py, e.pz, e.rv, e.nz);
               $display("%0t:          actual   x=%0d y=%0d z=%0d v=%0b nz=%0b", $time,
                        rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_range_valid,
                        rsp_near_zero_scale);
               errors++;
            end
         end
      end
   end

   initial begin
      #10000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      for (int k = 0; k < 8; k++) cfg_reg[k] = '0;
      cfg_reg[sdx_pkg::CSR_INVALID] = 63'hFFFF;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int p = 0; p < 4; p++) test_random_camera(300);
      test_random_regs(250);
      test_backpressure();
      test_random_camera(100);
      if (pending_xyz.size() != 0) errors++;
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
